### rtl/sha1h_pkg.sv
// Shared constants, command and status types for the streaming SHA-1 hasher.
package sha1h_pkg;

   // Initial chaining values h0 to h4.
   localparam logic [31:0] IV0 = 32'h67452301;
   localparam logic [31:0] IV1 = 32'hEFCDAB89;
   localparam logic [31:0] IV2 = 32'h98BADCFE;
   localparam logic [31:0] IV3 = 32'h10325476;
   localparam logic [31:0] IV4 = 32'hC3D2E1F0;

   // Round constants, one for each group of twenty rounds.
   localparam logic [31:0] K_CH  = 32'h5A827999;
   localparam logic [31:0] K_PAR = 32'h6ED9EBA1;
   localparam logic [31:0] K_MAJ = 32'h8F1BBCDC;
   localparam logic [31:0] K_FIN = 32'hCA62C1D6;

   // Padding marker byte.
   localparam logic [7:0] PAD_BYTE = 8'h80;

   // Round groups, which pick the round function and constant.
   localparam logic [1:0] PH_CH  = 2'd0;
   localparam logic [1:0] PH_PAR = 2'd1;
   localparam logic [1:0] PH_MAJ = 2'd2;
   localparam logic [1:0] PH_FIN = 2'd3;

   // Source of a byte written into the block buffer.
   localparam logic [1:0] BSEL_MSG  = 2'd0;
   localparam logic [1:0] BSEL_X80  = 2'd1;
   localparam logic [1:0] BSEL_ZERO = 2'd2;
   localparam logic [1:0] BSEL_LEN  = 2'd3;

   // Round counter limits and group boundaries.
   localparam logic [6:0] ROUND_LAST = 7'd79;
   localparam logic [6:0] ROUND_G1   = 7'd20;
   localparam logic [6:0] ROUND_G2   = 7'd40;
   localparam logic [6:0] ROUND_G3   = 7'd60;

   // Byte positions within a 64-byte block that steer the padding.
   localparam logic [5:0] POS_LAST     = 6'd63;
   localparam logic [5:0] POS_BEFORE_LEN = 6'd55;

   // Digest word indexes.
   localparam logic [2:0] WORD_FIRST = 3'd0;
   localparam logic [2:0] WORD_LAST  = 3'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       byte_wr;
      logic [1:0] byte_sel;
      logic       count_inc;
      logic       load_vars;
      logic       round_en;
      logic [1:0] phase;
      logic       add_chain;
      logic       out_load;
      logic [2:0] out_sel;
      logic       out_last;
      logic       restart;
   } sha1h_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [5:0] pos;
      logic       out_free;
   } sha1h_status_type;

endpackage

### rtl/sha1_stream_hasher_top.sv
// Top level of the streaming SHA-1 hasher: controller, datapath and checks.
//
// Computes the SHA-1 digest of a message that arrives one byte per transaction and returns
// the five digest words h0 to h4 as five result transactions, word_last marking h4; the
// block then starts the next message from the initial values. A byte that does not fill
// a 64-byte block is taken with the input kept ready. The byte that fills a block holds
// off the input through 80 rounds of one round per cycle and the chaining add.
// An end-of-message transaction pads in hardware at one byte per cycle (up to the rest of
// the block, plus a full block when the length does not fit), runs one or two compressions,
// and then loads one digest word per cycle into the output register as it frees up. A new
// transaction is accepted while the last digest word still waits.
// Over long messages, intake is held off during each block's compression in the single
// round unit.
module sha1_stream_hasher_top import sha1h_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_msg_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic        rsp_word_last
);

   sha1h_cmd_type    cmd;
   sha1h_status_type status;

   sha1h_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_has_byte (req_has_byte),
      .req_msg_end  (req_msg_end),
      .req_ready    (req_ready),
      .status       (status),
      .cmd          (cmd)
   );

   sha1h_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_data_byte   (req_data_byte),
      .cmd             (cmd),
      .status          (status),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_last   (rsp_word_last)
   );

   // A digest word is loaded only when the output register can take it.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("digest word loaded over an untaken result");

   // Rounds always follow a load of the working variables.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_vars |=> cmd.round_en)
      else $error("compression did not start after loading the working variables");

   // The schedule window never shifts and takes a byte in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.round_en && cmd.byte_wr))
      else $error("byte write collided with a compression round");

   // No input is taken while a block is being compressed.
   assert property (@(posedge clock) disable iff (reset)
      cmd.round_en |-> !req_ready)
      else $error("input accepted during compression");

endmodule

### rtl/sha1h_datapath.sv
// Datapath: block buffer and schedule window, round logic, chaining words, counts, output.
module sha1h_datapath import sha1h_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [7:0]       req_data_byte,
   input  sha1h_cmd_type    cmd,
   output sha1h_status_type status,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output logic [31:0]      rsp_digest_word,
   output logic             rsp_word_last
);

   logic [31:0] chain_ff [5];
   logic [31:0] chain_in [5];
   logic [31:0] sched_ff [16];
   logic [31:0] sched_in [16];
   logic [31:0] vars_ff  [5];
   logic [31:0] vars_in  [5];
   logic [60:0] count_ff;
   logic [60:0] count_in;
   logic [5:0]  pos_ff;
   logic [5:0]  pos_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [31:0] rsp_word_ff;
   logic [31:0] rsp_word_in;
   logic        rsp_last_ff;
   logic        rsp_last_in;

   logic [63:0] len_bits;
   logic [5:0]  len_shift;
   logic [7:0]  wr_byte;
   logic [4:0]  lane_base;
   logic [31:0] func_f;
   logic [31:0] round_k;
   logic [31:0] round_t;
   logic [31:0] sched_new;

   // Bit length of the message, and the byte of it that goes at the current position.
   assign len_bits  = {count_ff, 3'b000};
   assign len_shift = {~pos_ff[2:0], 3'b000};
   assign lane_base = {~pos_ff[1:0], 3'b000};

   always_comb begin
      unique case (cmd.byte_sel)
         BSEL_MSG:  wr_byte = req_data_byte;
         BSEL_X80:  wr_byte = PAD_BYTE;
         BSEL_ZERO: wr_byte = 8'h00;
         BSEL_LEN:  wr_byte = len_bits[len_shift +: 8];
         default:   wr_byte = 8'h00;
      endcase
   end

   // Round function and constant for the current group of rounds.
   always_comb begin
      unique case (cmd.phase)
         PH_CH: begin
            func_f  = (vars_ff[1] & vars_ff[2]) | (~vars_ff[1] & vars_ff[3]);
            round_k = K_CH;
         end
         PH_PAR: begin
            func_f  = vars_ff[1] ^ vars_ff[2] ^ vars_ff[3];
            round_k = K_PAR;
         end
         PH_MAJ: begin
            func_f  = (vars_ff[1] & vars_ff[2]) | (vars_ff[1] & vars_ff[3])
                    | (vars_ff[2] & vars_ff[3]);
            round_k = K_MAJ;
         end
         PH_FIN: begin
            func_f  = vars_ff[1] ^ vars_ff[2] ^ vars_ff[3];
            round_k = K_FIN;
         end
         default: begin
            func_f  = 32'h0;
            round_k = 32'h0;
         end
      endcase
   end

   assign round_t = {vars_ff[0][26:0], vars_ff[0][31:27]} + func_f + vars_ff[4]
                  + round_k + sched_ff[0];

   // Next schedule word from the fixed taps of the sixteen-word window.
   assign sched_new = {sched_ff[13] ^ sched_ff[8] ^ sched_ff[2] ^ sched_ff[0]} << 1
                    | {31'h0, sched_ff[13][31] ^ sched_ff[8][31] ^ sched_ff[2][31]
                       ^ sched_ff[0][31]};

   // The window shifts by one word each round; between blocks it takes bytes.
   always_comb begin
      sched_in = sched_ff;
      if (cmd.round_en) begin
         for (int i = 0; i < 15; i++) begin
            sched_in[i] = sched_ff[i + 1];
         end
         sched_in[15] = sched_new;
      end else if (cmd.byte_wr) begin
         sched_in[pos_ff[5:2]][lane_base +: 8] = wr_byte;
      end
   end

   // Working variables: loaded from the chain, then stepped once per round.
   always_comb begin
      vars_in = vars_ff;
      if (cmd.load_vars) begin
         vars_in = chain_ff;
      end else if (cmd.round_en) begin
         vars_in[0] = round_t;
         vars_in[1] = vars_ff[0];
         vars_in[2] = {vars_ff[1][1:0], vars_ff[1][31:2]};
         vars_in[3] = vars_ff[2];
         vars_in[4] = vars_ff[3];
      end
   end

   // Chaining words: restart to the initial values, or add in a finished block.
   always_comb begin
      chain_in = chain_ff;
      if (cmd.restart) begin
         chain_in[0] = IV0;
         chain_in[1] = IV1;
         chain_in[2] = IV2;
         chain_in[3] = IV3;
         chain_in[4] = IV4;
      end else if (cmd.add_chain) begin
         for (int i = 0; i < 5; i++) begin
            chain_in[i] = chain_ff[i] + vars_ff[i];
         end
      end
   end

   // Byte position in the block and running message length.
   always_comb begin
      pos_in   = pos_ff;
      count_in = count_ff;
      if (cmd.restart) begin
         pos_in   = 6'd0;
         count_in = 61'd0;
      end else begin
         if (cmd.byte_wr) begin
            pos_in = pos_ff + 6'd1;
         end
         if (cmd.count_inc) begin
            count_in = count_ff + 61'd1;
         end
      end
   end

   // Output register for one digest word per transaction.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = chain_ff[cmd.out_sel];
         rsp_last_in  = cmd.out_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff[0]  <= IV0;
         chain_ff[1]  <= IV1;
         chain_ff[2]  <= IV2;
         chain_ff[3]  <= IV3;
         chain_ff[4]  <= IV4;
         pos_ff       <= 6'd0;
         count_ff     <= 61'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         chain_ff     <= chain_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sched_ff    <= sched_in;
      vars_ff     <= vars_in;
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign status.pos      = pos_ff;
   assign status.out_free = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_digest_word = rsp_word_ff;
   assign rsp_word_last   = rsp_last_ff;

endmodule

### rtl/sha1h_ctrl.sv
// Controller: sequences byte intake, block compression, padding and digest output.
module sha1h_ctrl import sha1h_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_has_byte,
   input  logic             req_msg_end,
   output logic             req_ready,
   input  sha1h_status_type status,
   output sha1h_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ROUND = 3'd1;
   localparam logic [2:0] ST_ADD   = 3'd2;
   localparam logic [2:0] ST_PAD   = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic [6:0] round_ff;
   logic [6:0] round_in;
   logic       pend_end_ff;
   logic       pend_end_in;
   logic       padding_ff;
   logic       padding_in;
   logic       first_ff;
   logic       first_in;
   logic       len_ff;
   logic       len_in;
   logic [2:0] word_ff;
   logic [2:0] word_in;

   assign req_ready = (state_ff == ST_IDLE);

   // Next state and commands.
   always_comb begin
      state_in    = state_ff;
      round_in    = round_ff;
      pend_end_in = pend_end_ff;
      padding_in  = padding_ff;
      first_in    = first_ff;
      len_in      = len_ff;
      word_in     = word_ff;
      cmd         = '0;

      // Round group from the round counter.
      if (round_ff < ROUND_G1) begin
         cmd.phase = PH_CH;
      end else if (round_ff < ROUND_G2) begin
         cmd.phase = PH_PAR;
      end else if (round_ff < ROUND_G3) begin
         cmd.phase = PH_MAJ;
      end else begin
         cmd.phase = PH_FIN;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.byte_wr   = req_has_byte;
               cmd.byte_sel  = BSEL_MSG;
               cmd.count_inc = req_has_byte;
               if (req_has_byte && status.pos == POS_LAST) begin
                  // The byte completes a block: compress before anything else.
                  cmd.load_vars = 1'b1;
                  round_in      = 7'd0;
                  pend_end_in   = req_msg_end;
                  state_in      = ST_ROUND;
               end else if (req_msg_end) begin
                  padding_in = 1'b1;
                  first_in   = 1'b1;
                  len_in     = 1'b0;
                  state_in   = ST_PAD;
               end
            end
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            round_in     = round_ff + 7'd1;
            if (round_ff == ROUND_LAST) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            cmd.add_chain = 1'b1;
            if (padding_ff) begin
               if (len_ff) begin
                  word_in  = WORD_FIRST;
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_PAD;
               end
            end else if (pend_end_ff) begin
               pend_end_in = 1'b0;
               padding_in  = 1'b1;
               first_in    = 1'b1;
               len_in      = 1'b0;
               state_in    = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            // One padding byte per cycle: the marker, zero fill, then the length.
            cmd.byte_wr = 1'b1;
            if (first_ff) begin
               cmd.byte_sel = BSEL_X80;
            end else if (len_ff) begin
               cmd.byte_sel = BSEL_LEN;
            end else begin
               cmd.byte_sel = BSEL_ZERO;
            end
            first_in = 1'b0;
            if (status.pos == POS_BEFORE_LEN) begin
               len_in = 1'b1;
            end
            if (status.pos == POS_LAST) begin
               cmd.load_vars = 1'b1;
               round_in      = 7'd0;
               state_in      = ST_ROUND;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = word_ff;
               cmd.out_last = (word_ff == WORD_LAST);
               word_in      = word_ff + 3'd1;
               if (word_ff == WORD_LAST) begin
                  cmd.restart = 1'b1;
                  padding_in  = 1'b0;
                  len_in      = 1'b0;
                  pend_end_in = 1'b0;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         round_ff    <= 7'd0;
         pend_end_ff <= 1'b0;
         padding_ff  <= 1'b0;
         first_ff    <= 1'b0;
         len_ff      <= 1'b0;
         word_ff     <= WORD_FIRST;
      end else begin
         state_ff    <= state_in;
         round_ff    <= round_in;
         pend_end_ff <= pend_end_in;
         padding_ff  <= padding_in;
         first_ff    <= first_in;
         len_ff      <= len_in;
         word_ff     <= word_in;
      end
   end

endmodule
